// ===== hdl/cfpc_pkg.sv =====
package cfpc_pkg;

    // Egress queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int TAG_W   = 16;
    localparam int SIZE_W  = 16;
    localparam int NODE_W  = 16;
    localparam int LIMIT_W = 20;
    localparam int TOTAL_W = 48;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;

    // Queued bytes never exceed QUEUE_DEPTH * (2**SIZE_W - 1)
    localparam int QBYTES_W = QPTR_W + SIZE_W;
    localparam int CMP_W    = (QBYTES_W + 1 > LIMIT_W) ? QBYTES_W + 1 : LIMIT_W;
    localparam int CRED_W   = LIMIT_W + 1;

    // Drain limit per tick
    localparam int MAX_OUT = 16;
    localparam int NCNT_W  = $clog2(MAX_OUT + 1);

    // Size used when a message carries no size
    localparam int DEFAULT_BYTES = 64;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SELF_NODE     = 2'd0,
        REG_BUFFER_LIMIT  = 2'd1,
        REG_CREDIT_WINDOW = 2'd2
    } cfg_reg_t;

    typedef enum logic [OP_W-1:0] {
        OP_SEND    = 2'd0,
        OP_TICK    = 2'd1,
        OP_CREDIT  = 2'd2,
        OP_DELIVER = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_SEND   = 3'd0,
        CMD_RESET  = 3'd1,
        CMD_TICK   = 3'd2,
        CMD_CREDIT = 3'd3,
        CMD_RETURN = 3'd4
    } cmd_kind_t;

    typedef enum logic [KIND_W-1:0] {
        RES_SEND_RSP = 2'd0,
        RES_XMIT     = 2'd1,
        RES_CREDIT   = 2'd2,
        RES_RESET    = 2'd3
    } res_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [TAG_W-1:0]   tag;
        logic [SIZE_W-1:0]  bytes;
        logic               ctl;
        logic [NODE_W-1:0]  peer;
    } cmd_t;

    typedef struct packed {
        res_kind_t          kind;
        logic               accepted;
        logic [TAG_W-1:0]   tag;
        logic [SIZE_W-1:0]  bytes;
        logic [NODE_W-1:0]  src;
        logic [NODE_W-1:0]  dst;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        logic              ctl;
    } qent_t;

    // Handshake between a producer and a consumer of commands
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

endpackage

// ===== hdl/cfpc_front.sv =====
module cfpc_front (
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [cfpc_pkg::OP_W-1:0]    s_operation,
    input  logic [cfpc_pkg::TAG_W-1:0]   s_msg_tag,
    input  logic [cfpc_pkg::SIZE_W-1:0]  s_msg_size,
    input  logic                         s_is_control,
    input  logic                         s_is_reset,
    input  logic [cfpc_pkg::NODE_W-1:0]  s_peer_node,
    output cfpc_pkg::cmd_push_t          push,
    input  logic                         push_ready
);
    import cfpc_pkg::*;

    logic              drop;
    logic [SIZE_W-1:0] eff_bytes;
    cmd_t              cmd;

    // Zero size means no size given
    assign eff_bytes = (s_msg_size == '0) ? SIZE_W'(DEFAULT_BYTES) : s_msg_size;

    always_comb begin
        drop      = 1'b0;
        cmd.kind  = CMD_SEND;
        cmd.tag   = s_msg_tag;
        cmd.bytes = eff_bytes;
        cmd.ctl   = s_is_control;
        cmd.peer  = s_peer_node;
        unique case (op_t'(s_operation))
            OP_SEND: begin
                cmd.kind = s_is_reset ? CMD_RESET : CMD_SEND;
            end
            OP_TICK: begin
                cmd.kind = CMD_TICK;
            end
            OP_CREDIT: begin
                // raw amount; an empty credit changes nothing
                cmd.kind  = CMD_CREDIT;
                cmd.bytes = s_msg_size;
                drop      = (s_msg_size == '0);
            end
            OP_DELIVER: begin
                // control deliveries return no credit
                cmd.kind = CMD_RETURN;
                drop     = s_is_control;
            end
            default: begin
                drop = 1'b1;
            end
        endcase
    end

    assign s_ready    = push_ready;
    assign push.valid = s_valid & ~drop;
    assign push.cmd   = cmd;

endmodule

// ===== hdl/cfpc_cmdq.sv =====
module cfpc_cmdq (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfpc_pkg::cmd_push_t push,
    output logic                push_ready,
    output logic                pop_valid,
    output cfpc_pkg::cmd_t      pop_cmd,
    input  logic                pop_ready
);
    import cfpc_pkg::*;

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_push, do_pop;

    assign push_ready = (cnt_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                        : wr_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                        : rd_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CMDQ_CNT_W'(1);
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// ===== hdl/cfpc_back.sv =====
module cfpc_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cfpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             cmd_valid,
    input  cfpc_pkg::cmd_t                   cmd,
    output logic                             cmd_ready,
    output logic                             res_valid,
    output cfpc_pkg::res_t                   res,
    input  logic                             res_ready
);
    import cfpc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_CHK  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    qent_t               mem [QUEUE_DEPTH];
    qent_t               rd_data_reg;
    logic                mem_we;
    qent_t               wr_ent;

    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QPTR_W-1:0]   tail_reg, tail_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QBYTES_W-1:0] qbytes_reg, qbytes_next;
    logic [CRED_W-1:0]   credit_reg, credit_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [NCNT_W-1:0]   nsent_reg, nsent_next;
    res_t                held_reg, held_next;
    logic                held_vld_reg, held_vld_next;
    res_t                out_reg, out_data;
    logic                out_vld_reg, out_load;
    logic [NODE_W-1:0]   self_node_reg, self_node_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [LIMIT_W-1:0]  window_reg, window_next;

    logic                out_free;
    logic                send_ok;
    logic [CMP_W-1:0]    send_sum;
    logic [CRED_W-1:0]   credit_sum;
    logic                sendable;
    logic [TOTAL_W-1:0]  total_after;

    assign out_free    = ~out_vld_reg | res_ready;
    assign send_sum    = CMP_W'(qbytes_reg) + CMP_W'(cmd.bytes);
    assign send_ok     = (count_reg < QCNT_W'(QUEUE_DEPTH))
                       && ((limit_reg == '0) || (send_sum <= CMP_W'(limit_reg)));
    assign credit_sum  = credit_reg + CRED_W'(cmd.bytes);
    assign total_after = total_reg + TOTAL_W'(rd_data_reg.size);
    assign sendable    = (count_reg != '0) && (nsent_reg < NCNT_W'(MAX_OUT))
                       && (rd_data_reg.ctl || (window_reg == '0)
                           || (credit_reg >= CRED_W'(rd_data_reg.size)));

    assign wr_ent.tag  = cmd.tag;
    assign wr_ent.size = cmd.bytes;
    assign wr_ent.ctl  = cmd.ctl;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        qbytes_next    = qbytes_reg;
        credit_next    = credit_reg;
        total_next     = total_reg;
        nsent_next     = nsent_reg;
        held_next      = held_reg;
        held_vld_next  = held_vld_reg;
        self_node_next = self_node_reg;
        limit_next     = limit_reg;
        window_next    = window_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        out_load       = 1'b0;
        out_data       = '0;
        out_data.total = total_reg;
        out_data.last  = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_SEND: begin
                            if (out_free) begin
                                cmd_ready         = 1'b1;
                                out_load          = 1'b1;
                                out_data.kind     = RES_SEND_RSP;
                                out_data.accepted = send_ok;
                                if (send_ok) begin
                                    mem_we      = 1'b1;
                                    tail_next   = qptr_inc(tail_reg);
                                    count_next  = count_reg + QCNT_W'(1);
                                    qbytes_next = qbytes_reg + QBYTES_W'(cmd.bytes);
                                end
                            end
                        end
                        CMD_RESET: begin
                            if (out_free) begin
                                cmd_ready         = 1'b1;
                                out_load          = 1'b1;
                                out_data.kind     = RES_RESET;
                                out_data.accepted = 1'b1;
                                out_data.tag      = cmd.tag;
                            end
                        end
                        CMD_TICK: begin
                            cmd_ready     = 1'b1;
                            nsent_next    = '0;
                            held_vld_next = 1'b0;
                            state_next    = ST_RD;
                        end
                        CMD_CREDIT: begin
                            cmd_ready = 1'b1;
                            if (window_reg != '0) begin
                                credit_next = (credit_sum > CRED_W'(window_reg))
                                            ? CRED_W'(window_reg) : credit_sum;
                            end
                        end
                        CMD_RETURN: begin
                            if (out_free) begin
                                cmd_ready      = 1'b1;
                                out_load       = 1'b1;
                                out_data.kind  = RES_CREDIT;
                                out_data.bytes = cmd.bytes;
                                out_data.src   = self_node_reg;
                                out_data.dst   = cmd.peer;
                            end
                        end
                        default: begin
                            cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD: begin
                // head entry lands in rd_data_reg
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (sendable) begin
                    if (!held_vld_reg || out_free) begin
                        if (held_vld_reg) begin
                            out_load = 1'b1;
                            out_data = held_reg;
                        end
                        if (!rd_data_reg.ctl && (window_reg != '0)) begin
                            credit_next = credit_reg - CRED_W'(rd_data_reg.size);
                        end
                        total_next  = total_after;
                        qbytes_next = (qbytes_reg > QBYTES_W'(rd_data_reg.size))
                                    ? qbytes_reg - QBYTES_W'(rd_data_reg.size) : '0;
                        head_next   = qptr_inc(head_reg);
                        count_next  = count_reg - QCNT_W'(1);
                        nsent_next  = nsent_reg + NCNT_W'(1);
                        held_next          = '0;
                        held_next.kind     = RES_XMIT;
                        held_next.tag      = rd_data_reg.tag;
                        held_next.bytes    = rd_data_reg.size;
                        held_next.total    = total_after;
                        held_vld_next      = 1'b1;
                        state_next         = ST_RD;
                    end
                end else if (!held_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    // close the drain: the held item is the final one
                    out_load      = 1'b1;
                    out_data      = held_reg;
                    out_data.last = 1'b1;
                    held_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SELF_NODE:     self_node_next = cfg_wdata[NODE_W-1:0];
                REG_BUFFER_LIMIT:  limit_next     = cfg_wdata[LIMIT_W-1:0];
                REG_CREDIT_WINDOW: begin
                    window_next = cfg_wdata[LIMIT_W-1:0];
                    credit_next = CRED_W'(cfg_wdata[LIMIT_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            qbytes_reg    <= '0;
            credit_reg    <= '0;
            total_reg     <= '0;
            nsent_reg     <= '0;
            held_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            self_node_reg <= '0;
            limit_reg     <= '0;
            window_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            qbytes_reg    <= qbytes_next;
            credit_reg    <= credit_next;
            total_reg     <= total_next;
            nsent_reg     <= nsent_next;
            held_vld_reg  <= held_vld_next;
            self_node_reg <= self_node_next;
            limit_reg     <= limit_next;
            window_reg    <= window_next;
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (res_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        if (out_load) begin
            out_reg <= out_data;
        end
    end

    // Egress entries: one write port at the tail, registered read at the head
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail_reg] <= wr_ent;
        end
        rd_data_reg <= mem[head_reg];
    end

    assign res_valid = out_vld_reg;
    assign res       = out_reg;

endmodule

// ===== hdl/credit_flow_control_port.sv =====
// Byte-credit flow control for one fabric port.
//
// Input channel (s_*): one item per event. operation selects send request,
// tick, credit arrival or delivery of a received message. Result channel
// (m_*): zero or more items per input; m_last marks the final one.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write self_node, the egress
// byte limit and the credit window (writing the window reloads the credit).
//
// Timing: the front takes an item in any cycle in which the two-entry command
// queue has room. The back executes one command at a time: a send, reset
// forward, credit return or credit arrival is handled from the idle state; a
// tick starts the drain, then for each transmitted item reads the head from
// the egress memory and then does the credit check, and finally closes the
// drain. Results come from the back's output register.
//
// Reset (aresetn low, synchronous) empties the egress queue, zeroes credit,
// totals and config registers. No clearing pass is needed. When the receiver
// stalls the output register holds its item, the back waits at the next result
// it must load, and the command queue fills before s_ready drops.
module credit_flow_control_port (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [cfpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [cfpc_pkg::OP_W-1:0]        s_operation,
    input  logic [cfpc_pkg::TAG_W-1:0]       s_msg_tag,
    input  logic [cfpc_pkg::SIZE_W-1:0]      s_msg_size,
    input  logic                             s_is_control,
    input  logic                             s_is_reset,
    input  logic [cfpc_pkg::NODE_W-1:0]      s_peer_node,
    // result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [cfpc_pkg::KIND_W-1:0]      m_kind,
    output logic                             m_accepted,
    output logic [cfpc_pkg::TAG_W-1:0]       m_tag_out,
    output logic [cfpc_pkg::SIZE_W-1:0]      m_bytes_out,
    output logic [cfpc_pkg::NODE_W-1:0]      m_src_node_out,
    output logic [cfpc_pkg::NODE_W-1:0]      m_dst_node_out,
    output logic [cfpc_pkg::TOTAL_W-1:0]     m_sent_total,
    output logic                             m_last
);
    import cfpc_pkg::*;

    cmd_push_t push;
    logic      push_ready;
    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_ready;
    res_t      res;

    // Front: classify the item, drop events that do nothing
    cfpc_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_msg_tag    (s_msg_tag),
        .s_msg_size   (s_msg_size),
        .s_is_control (s_is_control),
        .s_is_reset   (s_is_reset),
        .s_peer_node  (s_peer_node),
        .push         (push),
        .push_ready   (push_ready)
    );

    // Decouple front from back
    cfpc_cmdq u_cmdq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (cmd_valid),
        .pop_cmd    (cmd),
        .pop_ready  (cmd_ready)
    );

    // Back: egress queue, credit, drain sequencer, output register
    cfpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res_valid (m_valid),
        .res       (res),
        .res_ready (m_ready)
    );

    assign m_kind         = res.kind;
    assign m_accepted     = res.accepted;
    assign m_tag_out      = res.tag;
    assign m_bytes_out    = res.bytes;
    assign m_src_node_out = res.src;
    assign m_dst_node_out = res.dst;
    assign m_sent_total   = res.total;
    assign m_last         = res.last;

endmodule

// ===== hdl/cfpc_checker.sv =====
module cfpc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [cfpc_pkg::KIND_W-1:0]   m_kind,
    input logic                          m_accepted,
    input logic [cfpc_pkg::TAG_W-1:0]    m_tag_out,
    input logic [cfpc_pkg::SIZE_W-1:0]   m_bytes_out,
    input logic [cfpc_pkg::TOTAL_W-1:0]  m_sent_total,
    input logic                          m_last
);
    import cfpc_pkg::*;

    // No result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_tag_out)
            && $stable(m_bytes_out) && $stable(m_sent_total) && $stable(m_last))
        else $error("stalled item changed");

    // Single-result events always close their input
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == RES_SEND_RSP || m_kind == RES_RESET
            || m_kind == RES_CREDIT) |-> m_last)
        else $error("single-result item without last");

    // Only send responses and reset forwards report acceptance
    a_accept_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_kind == RES_SEND_RSP || m_kind == RES_RESET)
        else $error("accepted set on wrong kind");

    // Reset forward is always accepted and carries no bytes
    a_reset_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == RES_RESET |-> m_accepted && m_bytes_out == '0)
        else $error("malformed reset forward");

endmodule

bind credit_flow_control_port cfpc_checker u_cfpc_checker (.*);
